>>> rtl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, no reset qualification
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

// clocked assertion, idle during reset
`define ASSERT_RST(label, prop, msg) \
  `ASSERT_CLK(label, disable iff (!rst_ni) prop, msg)

`endif

>>> rtl/db2dwt_pkg.sv
// ----------------------------------------------------------------------------
// db2dwt_pkg
// types, filter taps and index helpers of the db2 one level 2-d transform
// ----------------------------------------------------------------------------
package db2dwt_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 4096;
  localparam int RowSlots  = 4;
  localparam int AddrW     = $clog2(RowSlots * MaxWidth);
  localparam int ColW      = $clog2(MaxWidth);
  localparam int SlotW     = $clog2(RowSlots);

  localparam logic [1:0] CfgWidth  = 2'd0;
  localparam logic [1:0] CfgHeight = 2'd1;

  typedef struct packed {
    logic signed [17:0] sample;
    logic               frame_start;
  } dwt_in_t;

  typedef struct packed {
    logic signed [19:0] approx_coef;
    logic signed [19:0] vert_coef;
    logic signed [19:0] horz_coef;
    logic signed [19:0] diag_coef;
    logic [10:0]        out_row;
    logic [8:0]         out_col;
    logic               last_of_run;
    logic               frame_done;
  } dwt_out_t;

  typedef struct packed {
    logic [1:0]  cnt;
    logic [11:0] t0;
    logic [11:0] t1;
  } rdy_list_t;

  function automatic logic signed [15:0] tap_lo(input logic [1:0] idx);
    logic signed [15:0] v;
    case (idx)
      2'd0:    v = 16'sd15826;
      2'd1:    v = 16'sd27411;
      2'd2:    v = 16'sd7345;
      default: v = -16'sd4240;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] tap_hi(input logic [1:0] idx);
    logic signed [15:0] v;
    case (idx)
      2'd0:    v = -16'sd4240;
      2'd1:    v = -16'sd7345;
      2'd2:    v = 16'sd27411;
      default: v = -16'sd15826;
    endcase
    return v;
  endfunction

  // border mirror: -1 -> 1, n -> n-1
  function automatic logic [12:0] mirror(input logic signed [14:0] k,
                                         input logic [13:0] n);
    int kk;
    int nn;
    kk = int'(k);
    nn = int'(n);
    if (kk < 0) kk = -kk;
    else if (kk >= nn) kk = 2 * nn - kk - 1;
    if (kk < 0) kk = 0;
    if (kk >= nn) kk = nn - 1;
    return 13'(kk);
  endfunction

  // output indices whose last needed input index is k
  function automatic rdy_list_t ready_list(input logic [12:0] k, input logic [13:0] n);
    rdy_list_t r;
    int t;
    int last;
    int lim;
    int kk;
    r   = '0;
    kk  = int'(k);
    lim = (int'(n) + 1) >> 1;
    for (int m = 0; m < 2; m++) begin
      t = (kk >> 1) - 1 + m;
      if (t >= 0 && t < lim) begin
        last = 2 * t + 2;
        if (last > int'(n) - 1) last = int'(n) - 1;
        if (last == kk) begin
          if (r.cnt == 2'd0) r.t0 = 12'(t);
          else r.t1 = 12'(t);
          r.cnt = r.cnt + 2'd1;
        end
      end
    end
    return r;
  endfunction

  // round half up from 30 fraction bits, saturate to 20 bits
  function automatic logic signed [19:0] round_sat(input logic signed [55:0] acc);
    logic signed [55:0] t;
    logic signed [25:0] r;
    logic signed [19:0] o;
    t = acc + 56'sd536870912;
    r = 26'(t >>> 30);
    if (r > 26'sd524287) o = 20'sd524287;
    else if (r < -26'sd524288) o = -20'sd524288;
    else o = 20'(r);
    return o;
  endfunction

endpackage

>>> rtl/db2_dwt_2d_one_level_top.sv
// ----------------------------------------------------------------------------
// db2_dwt_2d_one_level_top
// one level of a separable 2-d db2 wavelet transform on a raster sample stream
// ----------------------------------------------------------------------------
// Samples enter in raster order, one word per handshake, and are written to a
// line store of four rows (row r in slot r mod 4). Set (i,j) uses rows and
// columns 2i-1..2i+2 mirrored at the borders, and is sent as soon as its last
// sample has arrived; one sample can release up to four sets, sent in row then
// column order. An input word that releases no set leaves the sequencer idle.
// Each set takes sixteen store reads, each followed by a vertical multiply-
// accumulate on the single read port, four horizontal accumulate steps and
// one rounding step, which waits while the output register is full. A finished
// set sits in the output register, so the next input word is taken while it
// waits. Configuration must be written only while idle; the block does not check.
`include "assert_macros.svh"

module db2_dwt_2d_one_level_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  db2dwt_pkg::dwt_in_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output db2dwt_pkg::dwt_out_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [12:0]         cfg_data_i
);
  import db2dwt_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;  // issue store read
  localparam logic [2:0] S_MAC  = 3'd2;  // vertical accumulate
  localparam logic [2:0] S_HOR  = 3'd3;  // horizontal accumulate
  localparam logic [2:0] S_FIN  = 3'd4;  // round and hand to output

  // configuration
  logic [10:0] width_q;
  logic [12:0] height_q;

  // position and per-word run info
  logic [11:0] in_row_q, in_row_d;
  logic [9:0]  in_col_q, in_col_d;
  logic [2:0]  fsm_q, fsm_d;
  logic [10:0] w_q;
  logic [12:0] h_q;
  logic [1:0]  nr_q, nc_q;
  logic [10:0] rows_q [2];
  logic [8:0]  cols_q [2];
  logic        a_q, b_q;
  logic [1:0]  fi_q, fj_q;

  // datapath
  logic signed [17:0] mem_q [RowSlots * MaxWidth];
  logic signed [17:0] rdata_q;
  logic signed [35:0] vl_q, vh_q;
  logic signed [55:0] acc_a_q, acc_v_q, acc_h_q, acc_d_q;
  logic               out_valid_q;
  dwt_out_t           out_q;

  logic        in_acc;
  logic [10:0] w_clamp;
  logic [12:0] h_clamp;
  logic [11:0] r_cur;
  logic [9:0]  c_cur;
  rdy_list_t   rl_row, rl_col;

  logic [10:0]        cur_i;
  logic [8:0]         cur_j;
  logic [12:0]        rd_y, rd_x;
  logic [AddrW-1:0]   rd_addr, wr_addr;
  logic signed [33:0] pv_lo, pv_hi;
  logic signed [51:0] ph_a, ph_v, ph_h, ph_d;
  logic               last_set, can_load;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (fsm_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd1024;
      height_q <= 13'd1024;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgWidth:  width_q  <= cfg_data_i[10:0];
        CfgHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp size to the supported range
  always_comb begin
    w_clamp = width_q;
    if (width_q < 11'd2) w_clamp = 11'd2;
    else if (width_q > 11'(MaxWidth)) w_clamp = 11'(MaxWidth);
    h_clamp = height_q;
    if (height_q < 13'd2) h_clamp = 13'd2;
    else if (height_q > 13'(MaxHeight)) h_clamp = 13'(MaxHeight);
  end

  // position of this word, restart on frame start or out-of-size position
  always_comb begin
    r_cur = in_row_q;
    c_cur = in_col_q;
    if (in_data_i.frame_start || ({1'b0, in_row_q} >= h_clamp) ||
        ({1'b0, in_col_q} >= w_clamp)) begin
      r_cur = '0;
      c_cur = '0;
    end
    in_row_d = r_cur;
    in_col_d = c_cur + 10'd1;
    if ({1'b0, c_cur} + 11'd1 >= w_clamp) begin
      in_col_d = '0;
      in_row_d = r_cur + 12'd1;
      if ({1'b0, r_cur} + 13'd1 >= h_clamp) in_row_d = '0;
    end
    rl_row = ready_list({1'b0, r_cur}, {1'b0, h_clamp});
    rl_col = ready_list({3'b0, c_cur}, {3'b0, w_clamp});
  end

  // store addressing
  assign cur_i   = rows_q[a_q];
  assign cur_j   = cols_q[b_q];
  assign rd_y    = mirror($signed({3'b0, cur_i, 1'b0}) - 15'sd1 + $signed({13'b0, fi_q}),
                          {1'b0, h_q});
  assign rd_x    = mirror($signed({5'b0, cur_j, 1'b0}) - 15'sd1 + $signed({13'b0, fj_q}),
                          {3'b0, w_q});
  assign rd_addr = {rd_y[SlotW-1:0], rd_x[ColW-1:0]};
  assign wr_addr = {r_cur[SlotW-1:0], c_cur[ColW-1:0]};

  // line store, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (in_acc) mem_q[wr_addr] <= in_data_i.sample;
    if (fsm_q == S_RD) rdata_q <= mem_q[rd_addr];
  end

  // products
  assign pv_lo = rdata_q * tap_lo(fi_q);
  assign pv_hi = rdata_q * tap_hi(fi_q);
  assign ph_a  = vl_q * tap_lo(fj_q);
  assign ph_v  = vl_q * tap_hi(fj_q);
  assign ph_h  = vh_q * tap_lo(fj_q);
  assign ph_d  = vh_q * tap_hi(fj_q);

  assign last_set = ({1'b0, a_q} == nr_q - 2'd1) && ({1'b0, b_q} == nc_q - 2'd1);
  assign can_load = !out_valid_q || out_ready_i;

  always_comb begin
    fsm_d = fsm_q;
    case (fsm_q)
      S_IDLE: if (in_acc && rl_row.cnt != 2'd0 && rl_col.cnt != 2'd0) fsm_d = S_RD;
      S_RD:   fsm_d = S_MAC;
      S_MAC:  fsm_d = (fi_q == 2'd3) ? S_HOR : S_RD;
      S_HOR:  fsm_d = (fj_q == 2'd3) ? S_FIN : S_RD;
      S_FIN:  if (can_load) fsm_d = last_set ? S_IDLE : S_RD;
      default: fsm_d = S_IDLE;
    endcase
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= S_IDLE;
      in_row_q    <= '0;
      in_col_q    <= '0;
      nr_q        <= '0;
      nc_q        <= '0;
      a_q         <= 1'b0;
      b_q         <= 1'b0;
      fi_q        <= '0;
      fj_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fsm_q <= fsm_d;
      if (in_acc) begin
        in_row_q <= in_row_d;
        in_col_q <= in_col_d;
        nr_q     <= rl_row.cnt;
        nc_q     <= rl_col.cnt;
        a_q      <= 1'b0;
        b_q      <= 1'b0;
        fi_q     <= '0;
        fj_q     <= '0;
      end
      if (fsm_q == S_MAC) fi_q <= fi_q + 2'd1;
      if (fsm_q == S_HOR) fj_q <= fj_q + 2'd1;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (fsm_q == S_FIN && can_load) begin
        out_valid_q <= 1'b1;
        // next set: column first, then row
        if ({1'b0, b_q} == nc_q - 2'd1) begin
          b_q <= 1'b0;
          a_q <= ~a_q;
        end else begin
          b_q <= ~b_q;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      w_q       <= w_clamp;
      h_q       <= h_clamp;
      rows_q[0] <= rl_row.t0[10:0];
      rows_q[1] <= rl_row.t1[10:0];
      cols_q[0] <= rl_col.t0[8:0];
      cols_q[1] <= rl_col.t1[8:0];
    end
    if (fsm_q == S_MAC) begin
      vl_q <= ((fi_q == 2'd0) ? 36'sd0 : vl_q) + 36'(pv_lo);
      vh_q <= ((fi_q == 2'd0) ? 36'sd0 : vh_q) + 36'(pv_hi);
    end
    if (fsm_q == S_HOR) begin
      acc_a_q <= ((fj_q == 2'd0) ? 56'sd0 : acc_a_q) + 56'(ph_a);
      acc_v_q <= ((fj_q == 2'd0) ? 56'sd0 : acc_v_q) + 56'(ph_v);
      acc_h_q <= ((fj_q == 2'd0) ? 56'sd0 : acc_h_q) + 56'(ph_h);
      acc_d_q <= ((fj_q == 2'd0) ? 56'sd0 : acc_d_q) + 56'(ph_d);
    end
    if (fsm_q == S_FIN && can_load) begin
      out_q.approx_coef <= round_sat(acc_a_q);
      out_q.vert_coef   <= round_sat(acc_v_q);
      out_q.horz_coef   <= round_sat(acc_h_q);
      out_q.diag_coef   <= round_sat(acc_d_q);
      out_q.out_row     <= cur_i;
      out_q.out_col     <= cur_j;
      out_q.last_of_run <= last_set;
      out_q.frame_done  <= ({2'b0, cur_i} == ((h_q + 13'd1) >> 1) - 13'd1) &&
                           ({2'b0, cur_j} == ((w_q + 11'd1) >> 1) - 11'd1);
    end
  end

  // checks
  `ASSERT_RST(a_accept_next, in_acc |=> (fsm_q == S_IDLE) || (fsm_q == S_RD), "bad state after accept")
  `ASSERT_RST(a_out_from_fin, $rose(out_valid_q) |-> $past(fsm_q) == S_FIN, "set sent from wrong state")
  `ASSERT_RST(a_mac_after_rd, fsm_q == S_MAC |-> $past(fsm_q) == S_RD, "accumulate without read")

endmodule
